// ----- hw/rtl/mcsd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcsd_pkg
// Types and constants shared by the segmentation cost block: beat payloads,
// register indexes and reset values, controller command and status groups.
// ----------------------------------------------------------------------------
package mcsd_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_COST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_COST       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNTH_PER_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNTH_QUADRATIC = 3'd4;

  localparam logic [10:0] RST_MAX_BLOCK       = 11'd500;
  localparam logic [31:0] RST_REUSE_COST      = 32'd83886080;
  localparam logic [31:0] RST_JOIN_COST       = 32'd25165824;
  localparam logic [31:0] RST_SYNTH_PER_BASE  = 32'd3355443;
  localparam logic [31:0] RST_SYNTH_QUADRATIC = 32'd0;

  typedef struct packed {
    logic [10:0] match_len;
    logic        seq_start;
  } in_item_t;

  typedef struct packed {
    logic [47:0] best_cost;
    logic [10:0] best_len;
    logic        best_is_reuse;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic pipe_busy;
    logic out_full;
  } sts_t;

endpackage

// ----- hw/rtl/mcsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcsd_ctrl
// Sequencer: takes one input beat, steps the datapath through the candidate
// block lengths, drains the compare pipeline and commits the result.
// ----------------------------------------------------------------------------
module mcsd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mcsd_pkg::sts_t sts,
  output mcsd_pkg::cmd_t cmd
);
  import mcsd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t state;
  logic   stall_q;

  assign in_stall   = stall_q;
  assign cmd.start  = in_valid && !stall_q;
  assign cmd.issue  = (state == ST_RUN);
  assign cmd.commit = (state == ST_DRAIN) && !sts.pipe_busy && !sts.out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state   <= ST_RUN;
            stall_q <= 1'b1;
          end
        end
        ST_RUN: begin
          if (sts.last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cmd.commit) begin
            state   <= ST_IDLE;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state   <= ST_IDLE;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/mcsd_datapath.sv -----
// ----------------------------------------------------------------------------
// mcsd_datapath
// Configuration registers, prefix cost ring memory, incremental synthesis
// cost, four-stage candidate pipeline, running minimum and output register.
// ----------------------------------------------------------------------------
module mcsd_datapath #(
  parameter int MAX_BLOCK = 1024,
  parameter int COST_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [mcsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data,
  input  mcsd_pkg::in_item_t                in_data,
  input  mcsd_pkg::cmd_t                    cmd,
  output mcsd_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mcsd_pkg::out_item_t               out_data
);
  import mcsd_pkg::*;

  localparam int WW = $clog2(MAX_BLOCK + 2);
  localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int LW = 32 + WW;
  localparam int QW = 32 + 2 * WW;
  localparam int DW = 33 + WW;
  localparam int XW = ((COST_BITS > QW) ? COST_BITS : QW) + 1;
  localparam logic [XW-1:0] CMAX_X = XW'({COST_BITS{1'b1}});
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_BLOCK - 1);
  localparam logic [WW-1:0] POS_MAX = WW'(MAX_BLOCK);

  function automatic logic [COST_BITS-1:0] sat(input logic [XW-1:0] v);
    return (v > CMAX_X) ? CMAX_X[COST_BITS-1:0] : v[COST_BITS-1:0];
  endfunction

  // configuration
  logic [10:0] max_block;
  logic [31:0] reuse_cost;
  logic [31:0] join_cost;
  logic [31:0] synth_per_base;
  logic [31:0] synth_quadratic;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block       <= RST_MAX_BLOCK;
      reuse_cost      <= RST_REUSE_COST;
      join_cost       <= RST_JOIN_COST;
      synth_per_base  <= RST_SYNTH_PER_BASE;
      synth_quadratic <= RST_SYNTH_QUADRATIC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BLOCK:       max_block       <= cfg_data[10:0];
        CFG_REUSE_COST:      reuse_cost      <= cfg_data;
        CFG_JOIN_COST:       join_cost       <= cfg_data;
        CFG_SYNTH_PER_BASE:  synth_per_base  <= cfg_data;
        CFG_SYNTH_QUADRATIC: synth_quadratic <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequence state
  logic [AW-1:0] head;
  logic [WW-1:0] position;
  logic [AW-1:0] head_sel;
  logic [WW-1:0] pos_sel;
  logic [WW-1:0] lim_sel;
  logic [WW-1:0] mb_eff;
  logic [WW-1:0] maxw_sel;
  logic [AW-1:0] wr_ptr;

  always_comb begin
    head_sel = in_data.seq_start ? '0 : head;
    pos_sel  = in_data.seq_start ? '0 : position;
    lim_sel  = pos_sel + WW'(1);
    if (max_block == 11'd0) begin
      mb_eff = WW'(1);
    end else if (32'(max_block) > 32'(MAX_BLOCK)) begin
      mb_eff = POS_MAX;
    end else begin
      mb_eff = WW'(max_block);
    end
    maxw_sel = (mb_eff < lim_sel) ? mb_eff : lim_sel;
    wr_ptr   = (head == LAST_SLOT) ? '0 : head + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      position <= '0;
    end else if (cmd.start) begin
      head     <= head_sel;
      position <= pos_sel;
    end else if (cmd.commit) begin
      head <= wr_ptr;
      if (position != POS_MAX) begin
        position <= position + WW'(1);
      end
    end
  end

  // candidate generator
  logic [WW-1:0] lim;
  logic [WW-1:0] maxw;
  logic [10:0]   match;
  logic [WW-1:0] w;
  logic [AW-1:0] rd_ptr;
  logic [LW-1:0] lin_acc;
  logic [QW-1:0] quad_acc;
  logic [DW-1:0] d_acc;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lim      <= lim_sel;
      maxw     <= maxw_sel;
      match    <= in_data.match_len;
      w        <= WW'(1);
      rd_ptr   <= head_sel;
      lin_acc  <= LW'(synth_per_base);
      quad_acc <= QW'(synth_quadratic);
      d_acc    <= (DW'(synth_quadratic) << 1) + DW'(synth_quadratic);
    end else if (cmd.issue) begin
      w        <= w + WW'(1);
      rd_ptr   <= (rd_ptr == '0) ? LAST_SLOT : rd_ptr - AW'(1);
      lin_acc  <= lin_acc + LW'(synth_per_base);
      quad_acc <= quad_acc + QW'(d_acc);
      d_acc    <= d_acc + (DW'(synth_quadratic) << 1);
    end
  end

  // stage 0: acquisition cost
  logic [COST_BITS-1:0] lin_c;
  logic [COST_BITS-1:0] quad_c;
  logic [COST_BITS-1:0] synth_c;
  logic                 reuse_c;

  always_comb begin
    lin_c   = sat(XW'(lin_acc));
    quad_c  = sat(XW'(quad_acc));
    synth_c = sat(XW'(lin_c) + XW'(quad_c));
    reuse_c = (32'(w) <= 32'(match));
  end

  logic                 s1_v, s2_v, s3_v;
  logic [COST_BITS-1:0] s1_acq, s2_acq;
  logic                 s1_join, s1_empty;
  logic [WW-1:0]        s1_w, s2_w, s3_w;
  logic                 s1_reuse, s2_reuse, s3_reuse;
  logic [COST_BITS-1:0] s2_hist;
  logic [COST_BITS-1:0] s3_path;
  logic [COST_BITS-1:0] mem_q;
  logic [COST_BITS-1:0] hist_mem [MAX_BLOCK];

  logic [COST_BITS-1:0] best;
  logic [WW-1:0]        best_w;
  logic                 best_reuse;
  logic                 have;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hist_mem[wr_ptr] <= best;
    end
    if (cmd.issue) begin
      mem_q <= hist_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= cmd.issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_acq   <= reuse_c ? sat(XW'(reuse_cost)) : synth_c;
    s1_join  <= (w < lim);
    s1_empty <= (w == lim);
    s1_w     <= w;
    s1_reuse <= reuse_c;

    s2_acq   <= s1_join ? sat(XW'(s1_acq) + XW'(join_cost)) : s1_acq;
    s2_hist  <= s1_empty ? '0 : mem_q;
    s2_w     <= s1_w;
    s2_reuse <= s1_reuse;

    s3_path  <= sat(XW'(s2_hist) + XW'(s2_acq));
    s3_w     <= s2_w;
    s3_reuse <= s2_reuse;
  end

  // running minimum, earliest wins
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      have <= 1'b0;
    end else if (s3_v && (!have || s3_path < best)) begin
      have       <= 1'b1;
      best       <= s3_path;
      best_w     <= s3_w;
      best_reuse <= s3_reuse;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.best_cost     <= 48'(best);
      out_data.best_len      <= 11'(best_w);
      out_data.best_is_reuse <= best_reuse;
    end
  end

  assign sts.last      = cmd.issue && (w == maxw);
  assign sts.pipe_busy = s1_v || s2_v || s3_v;
  assign sts.out_full  = out_valid;

endmodule

// ----- hw/rtl/min_cost_segmentation_dp.sv -----
// Result: maxw candidate lengths are tried per beat, maxw = min(max_block clamped to
//   1..MAX_BLOCK, 1-based position of the base within its sequence).
// Flow: the block takes no new input beat until the result is committed; a held result
//   delays the next commit. One prefix cost read per candidate length.
// Reset: control and configuration return to reset values; the cost memory is not
//   cleared, and the empty-prefix cost is supplied as zero.
// ----------------------------------------------------------------------------
// min_cost_segmentation_dp
// Minimum-cost segmentation of a target sequence, one base per beat, with
// reused and synthesised blocks and saturating fixed-point costs.
// ----------------------------------------------------------------------------
module min_cost_segmentation_dp #(
  parameter int MAX_BLOCK = 1024,
  parameter int COST_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mcsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mcsd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mcsd_pkg::out_item_t            out_data
);
  import mcsd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mcsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcsd_datapath #(
    .MAX_BLOCK (MAX_BLOCK),
    .COST_BITS (COST_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a beat");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not load the output register");

  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> in_stall)
    else $error("candidate issued while input open");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !sts.pipe_busy)
    else $error("new beat taken with candidates in flight");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segmentation cost block. Each accepted base is
// run through a local copy of the prefix-cost recurrence, and every result
// beat is compared field by field with the oldest prediction. Directed cases
// cover register edges, saturation and ties. Random phases follow, with
// varied block limits, costs, idling and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  import mcsd_pkg::*;

  localparam int                   HIST_DEPTH = 1024;
  localparam logic [63:0]          COST_SAT   = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  logic [47:0]  prefix_cost [0:HIST_DEPTH-1];
  int unsigned  base_pos = 0;
  int unsigned  ring_head = 0;
  logic [10:0]  blk_limit = RST_MAX_BLOCK;
  logic [63:0]  c_reuse = {32'd0, RST_REUSE_COST};
  logic [63:0]  c_join  = {32'd0, RST_JOIN_COST};
  logic [63:0]  c_lin   = {32'd0, RST_SYNTH_PER_BASE};
  logic [63:0]  c_quad  = {32'd0, RST_SYNTH_QUADRATIC};

  out_item_t    segment_q [$];
  int           mismatch_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_req = 1'b0;
  int           hold_left = 0;
  logic [10:0]  run_match = '0;

  min_cost_segmentation_dp dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (s < a || s > COST_SAT) return COST_SAT;
    return s;
  endfunction

  function automatic logic [63:0] synth_price(input int unsigned w);
    logic [63:0] lin;
    logic [63:0] quad;
    lin  = c_lin * w;
    quad = c_quad * w * w;
    return sat_sum(lin > COST_SAT ? COST_SAT : lin, quad > COST_SAT ? COST_SAT : quad);
  endfunction

  function automatic out_item_t best_segment(input in_item_t it);
    int unsigned lim;
    int unsigned mb;
    int unsigned maxw;
    int unsigned slot;
    logic [63:0] best;
    logic [63:0] path;
    int unsigned best_w;
    bit          best_reuse;
    bit          reuse;
    bit          have;
    out_item_t   r;
    best = '0;
    best_w = 0;
    best_reuse = 1'b0;
    have = 1'b0;
    if (it.seq_start) begin
      base_pos = 0;
      ring_head = 0;
      prefix_cost[0] = '0;
    end
    lim = base_pos + 1;
    mb = 32'(blk_limit);
    if (mb < 1) mb = 1;
    if (mb > HIST_DEPTH) mb = HIST_DEPTH;
    maxw = mb < lim ? mb : lim;
    for (int unsigned w = 1; w <= maxw; w++) begin
      slot = (ring_head + HIST_DEPTH - (w - 1)) % HIST_DEPTH;
      reuse = (w <= it.match_len);
      path = sat_sum({16'd0, prefix_cost[slot[9:0]]}, reuse ? c_reuse : synth_price(w));
      if (w < lim) path = sat_sum(path, c_join);
      if (!have || path < best) begin
        have = 1'b1;
        best = path;
        best_w = w;
        best_reuse = reuse;
      end
    end
    ring_head = (ring_head + 1) % HIST_DEPTH;
    prefix_cost[ring_head[9:0]] = best[47:0];
    if (base_pos < HIST_DEPTH) base_pos++;
    r.best_cost = best[47:0];
    r.best_len = best_w[10:0];
    r.best_is_reuse = best_reuse;
    return r;
  endfunction

  function automatic logic [31:0] rand_cost();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h0400_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [10:0] next_match();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) run_match = (run_match >= 11'd1024) ? 11'd1024 : run_match + 11'd1;
    else if (sel <= 7) run_match = 11'($urandom_range(0, 8));
    else if (sel == 8) run_match = 11'($urandom_range(0, 1024));
    else run_match = 11'($urandom_range(0, 2047));
    return run_match;
  endfunction

  // hold, then stall at random
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && out_valid && !out_stall) begin
      if (segment_q.size() == 0) begin
        $display("%0t: unexpected beat best_cost %h best_len %0d best_is_reuse %0b",
                 $time, out_data.best_cost, out_data.best_len, out_data.best_is_reuse);
        mismatch_cnt++;
      end else begin
        exp_item = segment_q.pop_front();
        if (out_data.best_cost !== exp_item.best_cost) begin
          $display("%0t: best_cost expected %h actual %h",
                   $time, exp_item.best_cost, out_data.best_cost);
          mismatch_cnt++;
        end
        if (out_data.best_len !== exp_item.best_len) begin
          $display("%0t: best_len expected %0d actual %0d",
                   $time, exp_item.best_len, out_data.best_len);
          mismatch_cnt++;
        end
        if (out_data.best_is_reuse !== exp_item.best_is_reuse) begin
          $display("%0t: best_is_reuse expected %0b actual %0b",
                   $time, exp_item.best_is_reuse, out_data.best_is_reuse);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic send_base(input logic [10:0] match, input logic first);
    in_item_t it;
    it.match_len = match;
    it.seq_start = first;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    segment_q.insert(segment_q.size(), best_segment(it));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_BLOCK:       blk_limit = data[10:0];
      CFG_REUSE_COST:      c_reuse = {32'd0, data};
      CFG_JOIN_COST:       c_join = {32'd0, data};
      CFG_SYNTH_PER_BASE:  c_lin = {32'd0, data};
      CFG_SYNTH_QUADRATIC: c_quad = {32'd0, data};
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (segment_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_costs(input logic [31:0] reuse, input logic [31:0] join_c,
                           input logic [31:0] lin, input logic [31:0] quad,
                           input logic [31:0] mb);
    write_reg(CFG_REUSE_COST, reuse);
    write_reg(CFG_JOIN_COST, join_c);
    write_reg(CFG_SYNTH_PER_BASE, lin);
    write_reg(CFG_SYNTH_QUADRATIC, quad);
    write_reg(CFG_MAX_BLOCK, mb);
  endtask

  task automatic test_reset_defaults();
    send_base(11'd0, 1'b0);
    send_base(11'd2047, 1'b0);
    send_base(11'd1024, 1'b0);
    send_base(11'd1, 1'b0);
    send_base(11'd0, 1'b1);
    send_base(11'd6, 1'b0);
  endtask

  task automatic test_block_limits();
    settle();
    write_reg(CFG_MAX_BLOCK, 32'd0);
    send_base(11'd3, 1'b0);
    send_base(11'd0, 1'b0);
    send_base(11'd1, 1'b0);
    settle();
    write_reg(CFG_MAX_BLOCK, 32'hABCD_07FF);
    write_reg(CFG_UNUSED, 32'h5A5A_A5A5);
    send_base(11'd0, 1'b0);
    send_base(11'd2, 1'b0);
    send_base(11'd5, 1'b1);
    send_base(11'd0, 1'b0);
  endtask

  task automatic test_saturation();
    settle();
    set_costs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1024);
    send_base(11'd0, 1'b1);
    send_base(11'd0, 1'b0);
    send_base(11'd1, 1'b0);
    send_base(11'd0, 1'b0);
    send_base(11'd2047, 1'b0);
    send_base(11'd0, 1'b0);
  endtask

  task automatic test_equal_costs();
    settle();
    set_costs(32'd0, 32'd0, 32'd0, 32'd0, 32'd16);
    send_base(11'd0, 1'b1);
    send_base(11'd4, 1'b0);
    send_base(11'd0, 1'b0);
    send_base(11'd9, 1'b0);
    send_base(11'd2, 1'b0);
  endtask

  task automatic test_random_phase(input int n, input logic [31:0] mb, input int seq_one_in,
                                   input int s_idle, input int r_stall, input bit quad_max);
    bit first;
    settle();
    set_costs(rand_cost(), rand_cost(), rand_cost(),
              quad_max ? 32'hFFFF_FFFF : rand_cost(), mb);
    send_idle_pct = s_idle;
    recv_stall_pct = r_stall;
    for (int k = 0; k < n; k++) begin
      first = (seq_one_in != 0) && ($urandom_range(1, seq_one_in) == 1);
      send_base(next_match(), first);
    end
  endtask

  task automatic test_backpressure();
    settle();
    set_costs(rand_cost(), rand_cost(), rand_cost(), rand_cost(), 32'd4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    for (int k = 0; k < 40; k++) send_base(next_match(), $urandom_range(0, 15) == 0);
  endtask

  task automatic test_drain_pause();
    settle();
    set_costs(rand_cost(), rand_cost(), rand_cost(), rand_cost(), $urandom_range(1, 24));
    send_idle_pct = 6;
    recv_stall_pct = 6;
    for (int k = 0; k < 15; k++) send_base(next_match(), $urandom_range(0, 19) == 0);
    in_valid <= 1'b0;
    while (segment_q.size() != 0) @(negedge clk);
    for (int k = 0; k < 15; k++) send_base(next_match(), $urandom_range(0, 19) == 0);
  endtask

  initial begin
    for (int k = 0; k < HIST_DEPTH; k++) prefix_cost[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_block_limits();
    test_saturation();
    test_equal_costs();
    test_random_phase(50, 32'd8, 20, 0, 0, 1'b0);
    test_random_phase(60, 32'd1, 0, 72, 0, 1'b0);
    test_random_phase(100, 32'd33, 0, 0, 72, 1'b0);
    test_random_phase(60, 32'd0, 0, 6, 6, 1'b0);
    test_random_phase(60, 32'd2047, 0, 0, 0, 1'b0);
    test_random_phase(40, 32'd1024, 0, 72, 0, 1'b1);
    test_backpressure();
    test_drain_pause();
    test_random_phase(60, 32'd5, 20, 0, 72, 1'b0);
    test_random_phase(60, $urandom_range(1, 64), 25, 6, 6, 1'b0);
    settle();
    repeat (1100) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/mcsd_pkg.sv
hw/rtl/mcsd_ctrl.sv
hw/rtl/mcsd_datapath.sv
hw/rtl/min_cost_segmentation_dp.sv
sim/tb_top.sv
